// ===== src/qbvg_pkg.sv =====
package qbvg_pkg;

  // result kinds
  localparam logic [1:0] KIND_VERTEX = 2'd0;
  localparam logic [1:0] KIND_BIND   = 2'd1;
  localparam logic [1:0] KIND_DCALL  = 2'd2;

  // input modes
  localparam logic [1:0] MODE_BEGIN = 2'd0;
  localparam logic [1:0] MODE_PLAIN = 2'd1;
  localparam logic [1:0] MODE_TEX   = 2'd2;
  localparam logic [1:0] MODE_END   = 2'd3;

  // angle constants in Q.28, CORDIC start value in Q2.30
  localparam logic signed [33:0] Q28_PI      = 34'sd843314857;
  localparam logic signed [33:0] Q28_HALF_PI = 34'sd421657428;
  localparam logic signed [33:0] Q30_GAIN    = 34'sd652032874;
  localparam int CORDIC_STEPS = 16;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] size_x;
    logic signed [31:0] size_y;
    logic signed [15:0] angle;
    logic [31:0]        color;
    logic [4:0]         slot;
    logic [31:0]        handle;
    logic [18:0]        total;
    logic               line;
  } cmd_t;

  // arctangent table, round(atan(2^-i) * 2^28)
  function automatic logic signed [33:0] atan_q28(input logic [3:0] i);
    logic signed [33:0] r;
    unique case (i)
      4'd0:  r = 34'sd210828714;
      4'd1:  r = 34'sd124459457;
      4'd2:  r = 34'sd65760959;
      4'd3:  r = 34'sd33381290;
      4'd4:  r = 34'sd16755422;
      4'd5:  r = 34'sd8385879;
      4'd6:  r = 34'sd4193963;
      4'd7:  r = 34'sd2097109;
      4'd8:  r = 34'sd1048571;
      4'd9:  r = 34'sd524287;
      4'd10: r = 34'sd262144;
      4'd11: r = 34'sd131072;
      4'd12: r = 34'sd65536;
      4'd13: r = 34'sd32768;
      4'd14: r = 34'sd16384;
      default: r = 34'sd8192;
    endcase
    return r;
  endfunction

endpackage

// ===== src/qbvg_in_if.sv =====
interface qbvg_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] size_x;
  logic signed [31:0] size_y;
  logic signed [15:0] angle;
  logic [31:0]        color;
  logic [31:0]        texture_handle;

  modport source (output valid, mode, pos_x, pos_y, size_x, size_y, angle, color,
                  texture_handle, input ready);
  modport sink (input valid, mode, pos_x, pos_y, size_x, size_y, angle, color,
                texture_handle, output ready);
endinterface

// ===== src/qbvg_out_if.sv =====
interface qbvg_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [31:0] vertex_x;
  logic signed [31:0] vertex_y;
  logic               tex_u;
  logic               tex_v;
  logic [31:0]        vertex_color;
  logic [4:0]         slot_number;
  logic [31:0]        bound_handle;
  logic [18:0]        total_indices;
  logic               line_mode;
  logic               last;

  modport source (output valid, kind, vertex_x, vertex_y, tex_u, tex_v, vertex_color,
                  slot_number, bound_handle, total_indices, line_mode, last,
                  input ready);
  modport sink (input valid, kind, vertex_x, vertex_y, tex_u, tex_v, vertex_color,
                slot_number, bound_handle, total_indices, line_mode, last,
                output ready);
endinterface

// ===== src/qbvg_front.sv =====
module qbvg_front #(
  parameter int SLOT_COUNT = 31,
  parameter int MAX_QUADS  = 65536
) (
  input  logic            clk,
  input  logic            rst_n,
  qbvg_in_if.sink         in_ch,
  input  logic            wireframe,
  output qbvg_pkg::cmd_t  push_cmd,
  output logic            push_valid,
  input  logic            push_ready
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);
  localparam logic [19:0] CAP = 20'(MAX_QUADS * 6);

  localparam logic F_IDLE = 1'b0;
  localparam logic F_WALK = 1'b1;

  logic              st_r, st_nxt;
  logic [CNT_W-1:0]  walk_r, walk_nxt;
  logic [31:0]       slot_r [SLOT_COUNT];
  logic [18:0]       total_r, total_nxt;

  logic              hit_any, emp_any;
  logic [IDX_W-1:0]  hit_idx, emp_idx;
  logic              textured, claim;
  logic [4:0]        slot_sel;
  logic [19:0]       total_inc;
  logic              accept;
  logic              walk_done, walk_full;
  logic [IDX_W-1:0]  walk_idx;

  assign accept     = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (st_r == F_IDLE) && push_ready;
  assign walk_done  = (walk_r == CNT_W'(SLOT_COUNT));
  assign walk_idx   = IDX_W'(walk_r);
  assign walk_full  = !walk_done && (slot_r[walk_idx] != 32'd0);

  // find matching and first empty slot, lowest index wins
  always_comb begin
    hit_any = 1'b0;
    emp_any = 1'b0;
    hit_idx = '0;
    emp_idx = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (slot_r[i] == in_ch.texture_handle) begin
        hit_any = 1'b1;
        hit_idx = IDX_W'(i);
      end
      if (slot_r[i] == 32'd0) begin
        emp_any = 1'b1;
        emp_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    textured = (in_ch.mode == qbvg_pkg::MODE_TEX) && (in_ch.texture_handle != 32'd0);
    claim    = 1'b0;
    slot_sel = 5'd0;
    if (textured) begin
      if (hit_any) begin
        slot_sel = 5'(hit_idx) + 5'd1;
      end else if (emp_any) begin
        slot_sel = 5'(emp_idx) + 5'd1;
        claim    = 1'b1;
      end
    end
  end

  // saturating index count
  always_comb begin
    total_inc = {1'b0, total_r} + 20'd6;
    if (total_inc > CAP) total_inc = CAP;
  end

  // build the queue beat
  always_comb begin
    push_cmd        = '0;
    push_valid      = 1'b0;
    if (st_r == F_IDLE) begin
      push_cmd.kind   = qbvg_pkg::KIND_VERTEX;
      push_cmd.pos_x  = in_ch.pos_x;
      push_cmd.pos_y  = in_ch.pos_y;
      push_cmd.size_x = in_ch.size_x;
      push_cmd.size_y = in_ch.size_y;
      push_cmd.angle  = in_ch.angle;
      push_cmd.color  = in_ch.color;
      push_cmd.slot   = slot_sel;
      push_valid      = in_ch.valid &&
                        (in_ch.mode == qbvg_pkg::MODE_PLAIN ||
                         in_ch.mode == qbvg_pkg::MODE_TEX);
    end else if (walk_done) begin
      push_cmd.kind  = qbvg_pkg::KIND_DCALL;
      push_cmd.total = total_r;
      push_cmd.line  = wireframe;
      push_valid     = 1'b1;
    end else begin
      push_cmd.kind   = qbvg_pkg::KIND_BIND;
      push_cmd.slot   = 5'(walk_r) + 5'd1;
      push_cmd.handle = slot_r[walk_idx];
      push_valid      = walk_full;
    end
  end

  // control sequencing
  always_comb begin
    st_nxt    = st_r;
    walk_nxt  = walk_r;
    total_nxt = total_r;
    unique case (st_r)
      F_IDLE: begin
        if (accept) begin
          unique case (in_ch.mode)
            qbvg_pkg::MODE_BEGIN: total_nxt = '0;
            qbvg_pkg::MODE_END: begin
              st_nxt   = F_WALK;
              walk_nxt = '0;
            end
            default: total_nxt = total_inc[18:0];
          endcase
        end
      end
      default: begin
        if (walk_done) begin
          if (push_ready) st_nxt = F_IDLE;
        end else if (!walk_full || push_ready) begin
          walk_nxt = walk_r + CNT_W'(1);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= F_IDLE;
      walk_r  <= '0;
      total_r <= '0;
    end else begin
      st_r    <= st_nxt;
      walk_r  <= walk_nxt;
      total_r <= total_nxt;
    end
  end

  // slot table: claim on draw, clear as binds leave
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOT_COUNT; i++) slot_r[i] <= '0;
    end else if (st_r == F_IDLE) begin
      if (accept && claim) slot_r[emp_idx] <= in_ch.texture_handle;
    end else if (walk_full && push_ready) begin
      slot_r[walk_idx] <= '0;
    end
  end

endmodule

// ===== src/qbvg_fifo.sv =====
module qbvg_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  qbvg_pkg::cmd_t push_cmd,
  input  logic           push_valid,
  output logic           push_ready,
  output qbvg_pkg::cmd_t pop_cmd,
  output logic           pop_valid,
  input  logic           pop_en
);

  localparam int AW = qbvg_pkg::QUEUE_AW;

  qbvg_pkg::cmd_t    mem_r [qbvg_pkg::QUEUE_DEPTH];
  logic [AW-1:0]     wp_r, rp_r;
  logic [AW:0]       cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign push_ready = (cnt_r != (AW+1)'(qbvg_pkg::QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_cmd    = mem_r[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_en && pop_valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + (AW+1)'(1);
    if (!do_push && do_pop) cnt_nxt = cnt_r - (AW+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) wp_r <= wp_r + AW'(1);
      if (do_pop)  rp_r <= rp_r + AW'(1);
    end
  end

  // hold queued beats
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= push_cmd;
  end

endmodule

// ===== src/qbvg_back.sv =====
module qbvg_back (
  input  logic           clk,
  input  logic           rst_n,
  input  qbvg_pkg::cmd_t pop_cmd,
  input  logic           pop_valid,
  output logic           pop_en,
  qbvg_out_if.source     out_ch
);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_CORD = 3'd1;
  localparam logic [2:0] B_MUL  = 3'd2;
  localparam logic [2:0] B_VERT = 3'd3;
  localparam logic [2:0] B_SEND = 3'd4;

  logic [2:0]          st_r, st_nxt;
  qbvg_pkg::cmd_t      cmd_r;
  logic [3:0]          cnt_r;
  logic [1:0]          mix_r;
  logic [1:0]          corner_r;
  logic                neg_r;
  logic signed [33:0]  x_r, y_r, z_r;
  logic signed [63:0]  p_r [4];

  logic                out_free;
  logic signed [33:0]  a0, a1, a_fold;
  logic                neg_fold;
  logic signed [33:0]  xs, ys;
  logic signed [33:0]  c_v, s_v, mb;
  logic signed [31:0]  ma;
  logic signed [65:0]  prod;
  logic                sux, svy;
  logic signed [65:0]  tx, ty;
  logic signed [35:0]  vx, vy;
  logic signed [31:0]  vx_sat, vy_sat;

  assign out_free = !out_ch.valid || out_ch.ready;
  assign pop_en   = (st_r == B_IDLE) && pop_valid;

  // range-reduce the angle into [-pi/2, pi/2]
  always_comb begin
    a0 = {{2{pop_cmd.angle[15]}}, pop_cmd.angle, 16'd0};
    a1 = a0;
    if (a1 > qbvg_pkg::Q28_PI) a1 = a1 - (qbvg_pkg::Q28_PI <<< 1);
    if (a1 < -qbvg_pkg::Q28_PI) a1 = a1 + (qbvg_pkg::Q28_PI <<< 1);
    a_fold   = a1;
    neg_fold = 1'b0;
    if (a1 > qbvg_pkg::Q28_HALF_PI) begin
      a_fold   = a1 - qbvg_pkg::Q28_PI;
      neg_fold = 1'b1;
    end else if (a1 < -qbvg_pkg::Q28_HALF_PI) begin
      a_fold   = a1 + qbvg_pkg::Q28_PI;
      neg_fold = 1'b1;
    end
  end

  // one CORDIC rotation and the shared multiplier operands
  always_comb begin
    xs   = x_r >>> cnt_r;
    ys   = y_r >>> cnt_r;
    c_v  = neg_r ? -x_r : x_r;
    s_v  = neg_r ? -y_r : y_r;
    ma   = mix_r[0] ? cmd_r.size_y : cmd_r.size_x;
    mb   = (mix_r[0] ^ mix_r[1]) ? s_v : c_v;
    prod = 66'(ma) * 66'(mb);
  end

  // corner offsets, centre add and saturation
  always_comb begin
    sux = (corner_r == 2'd1) || (corner_r == 2'd2);
    svy = corner_r[1];
    tx  = (sux ? 66'(p_r[0]) : -66'(p_r[0])) - (svy ? 66'(p_r[1]) : -66'(p_r[1]))
          + 66'sd1073741824;
    ty  = (sux ? 66'(p_r[2]) : -66'(p_r[2])) + (svy ? 66'(p_r[3]) : -66'(p_r[3]))
          + 66'sd1073741824;
    vx  = 36'(cmd_r.pos_x) + 36'(tx >>> 31);
    vy  = 36'(cmd_r.pos_y) + 36'(ty >>> 31);
    if (vx > 36'sd2147483647)       vx_sat = 32'sh7fffffff;
    else if (vx < -36'sd2147483648) vx_sat = 32'sh80000000;
    else                            vx_sat = vx[31:0];
    if (vy > 36'sd2147483647)       vy_sat = 32'sh7fffffff;
    else if (vy < -36'sd2147483648) vy_sat = 32'sh80000000;
    else                            vy_sat = vy[31:0];
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      B_IDLE: if (pop_valid) st_nxt = (pop_cmd.kind == qbvg_pkg::KIND_VERTEX) ? B_CORD : B_SEND;
      B_CORD: if (cnt_r == 4'(qbvg_pkg::CORDIC_STEPS - 1)) st_nxt = B_MUL;
      B_MUL:  if (mix_r == 2'd3) st_nxt = B_VERT;
      B_VERT: if (out_free && corner_r == 2'd3) st_nxt = B_IDLE;
      B_SEND: if (out_free) st_nxt = B_IDLE;
      default: st_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= B_IDLE;
      cnt_r    <= '0;
      mix_r    <= '0;
      corner_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (st_r == B_IDLE) begin
        cnt_r    <= '0;
        mix_r    <= '0;
        corner_r <= '0;
      end
      if (st_r == B_CORD) cnt_r <= cnt_r + 4'd1;
      if (st_r == B_MUL)  mix_r <= mix_r + 2'd1;
      if (st_r == B_VERT && out_free) corner_r <= corner_r + 2'd1;
    end
  end

  // datapath: latch command, rotate, multiply
  always_ff @(posedge clk) begin
    if (pop_en) begin
      cmd_r <= pop_cmd;
      x_r   <= qbvg_pkg::Q30_GAIN;
      y_r   <= '0;
      z_r   <= a_fold;
      neg_r <= neg_fold;
    end
    if (st_r == B_CORD) begin
      if (!z_r[33]) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - qbvg_pkg::atan_q28(cnt_r);
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + qbvg_pkg::atan_q28(cnt_r);
      end
    end
    if (st_r == B_MUL) p_r[mix_r] <= prod[63:0];
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_ch.valid <= 1'b0;
    end else if (out_free) begin
      out_ch.valid <= (st_r == B_VERT) || (st_r == B_SEND);
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_ch.kind          <= cmd_r.kind;
      out_ch.vertex_x      <= '0;
      out_ch.vertex_y      <= '0;
      out_ch.tex_u         <= 1'b0;
      out_ch.tex_v         <= 1'b0;
      out_ch.vertex_color  <= '0;
      out_ch.slot_number   <= cmd_r.slot;
      out_ch.bound_handle  <= cmd_r.handle;
      out_ch.total_indices <= cmd_r.total;
      out_ch.line_mode     <= cmd_r.line;
      out_ch.last          <= (cmd_r.kind == qbvg_pkg::KIND_DCALL);
      if (st_r == B_VERT) begin
        out_ch.vertex_x     <= vx_sat;
        out_ch.vertex_y     <= vy_sat;
        out_ch.tex_u        <= sux;
        out_ch.tex_v        <= svy;
        out_ch.vertex_color <= cmd_r.color;
        out_ch.last         <= (corner_r == 2'd3);
      end
    end
  end

endmodule

// ===== src/quad_batch_vertex_generator_top.sv =====
// Draw item: 16 CORDIC steps, 4 passes of the shared multiplier, 4 vertex
//   beats; one vertex per cycle out while the receiver is ready.
// End item: walks every slot, a bind beat per used slot, then the draw-call beat.
// Begin item: no beats. A 4-deep command queue parts front and back.
// Reset: synchronous, active low; clears slots, index count, wireframe, queue.
module quad_batch_vertex_generator_top #(
  parameter int SLOT_COUNT = 31,
  parameter int MAX_QUADS  = 65536
) (
  input  logic       clk,
  input  logic       rst_n,
  qbvg_in_if.sink    in_ch,
  qbvg_out_if.source out_ch,
  input  logic       cfg_we,
  input  logic       cfg_wdata
);

  logic           wireframe_r;
  qbvg_pkg::cmd_t push_cmd, pop_cmd;
  logic           push_valid, push_ready, pop_valid, pop_en;

  // hold the wireframe flag
  always_ff @(posedge clk) begin
    if (!rst_n) wireframe_r <= 1'b0;
    else if (cfg_we) wireframe_r <= cfg_wdata;
  end

  qbvg_front #(.SLOT_COUNT(SLOT_COUNT), .MAX_QUADS(MAX_QUADS)) u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .wireframe(wireframe_r),
    .push_cmd(push_cmd), .push_valid(push_valid), .push_ready(push_ready)
  );

  qbvg_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push_cmd(push_cmd), .push_valid(push_valid),
    .push_ready(push_ready), .pop_cmd(pop_cmd), .pop_valid(pop_valid), .pop_en(pop_en)
  );

  qbvg_back u_back (
    .clk(clk), .rst_n(rst_n), .pop_cmd(pop_cmd), .pop_valid(pop_valid),
    .pop_en(pop_en), .out_ch(out_ch)
  );

endmodule

// ===== dv/tb_quad_batch_vertex_generator_top.sv =====
`timescale 1ns / 1ps
module tb_quad_batch_vertex_generator_top;

  typedef struct {
    logic [1:0]         mode;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] size_x;
    logic signed [31:0] size_y;
    logic signed [15:0] angle;
    logic [31:0]        color;
    logic [31:0]        handle;
  } sprite_t;

  typedef struct {
    logic [1:0]         kind;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic               u;
    logic               v;
    logic [31:0]        color;
    logic [4:0]         slot;
    logic [31:0]        handle;
    logic [18:0]        total;
    logic               line;
    logic               last;
  } vert_t;

  localparam int SLOTS = 31;
  localparam logic [18:0] INDEX_CAP = 19'd393216;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;

  qbvg_in_if  in_ch();
  qbvg_out_if out_ch();

  quad_batch_vertex_generator_top uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // Predictor state
  logic [31:0] slot_tbl [SLOTS];
  logic [18:0] index_count;
  logic        line_flag;

  sprite_t pending_sprites[$];
  vert_t   expected_beats[$];
  int      mismatches = 0;
  bit      idle_enable = 1'b1;
  bit      send_hold = 1'b0;
  int      sink_holdoff = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic signed [63:0] asr(logic signed [63:0] v, int s);
    return v >>> s;
  endfunction

  function automatic logic signed [31:0] clamp32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  // Rotation-mode CORDIC giving cos and sin in Q2.30
  task automatic sincos(input logic signed [15:0] ang,
                        output logic signed [63:0] c, output logic signed [63:0] s);
    logic signed [63:0] a, x, y, nx;
    logic signed [63:0] tbl [16];
    bit flip;
    tbl = '{210828714, 124459457, 65760959, 33381290, 16755422, 8385879, 4193963,
            2097109, 1048571, 524287, 262144, 131072, 65536, 32768, 16384, 8192};
    a = 64'(ang) * 65536;
    x = 64'sd652032874;
    y = 0;
    flip = 0;
    if (a > 64'sd843314857) a -= 64'sd1686629714;
    if (a < -64'sd843314857) a += 64'sd1686629714;
    if (a > 64'sd421657428) begin
      a -= 64'sd843314857; flip = 1;
    end else if (a < -64'sd421657428) begin
      a += 64'sd843314857; flip = 1;
    end
    for (int i = 0; i < 16; i++) begin
      if (a >= 0) begin
        nx = x - asr(y, i); y = y + asr(x, i); a -= tbl[i];
      end else begin
        nx = x + asr(y, i); y = y - asr(x, i); a += tbl[i];
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  // Expand one accepted item into its expected beats
  task automatic predict_batch(input sprite_t it);
    vert_t r;
    logic signed [63:0] c, s, dx, dy, ox, oy;
    int slot;
    if (it.mode == qbvg_pkg::MODE_BEGIN) begin
      index_count = 0;
    end else if (it.mode == qbvg_pkg::MODE_END) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_tbl[i] != 0) begin
          r = '{qbvg_pkg::KIND_BIND, 0, 0, 0, 0, 0, 5'(i + 1), slot_tbl[i], 0, 0, 0};
          expected_beats.push_back(r);
          slot_tbl[i] = 0;
        end
      end
      r = '{qbvg_pkg::KIND_DCALL, 0, 0, 0, 0, 0, 0, 0, index_count, line_flag, 1};
      expected_beats.push_back(r);
    end else begin
      slot = 0;
      if (it.mode == qbvg_pkg::MODE_TEX && it.handle != 0) begin
        for (int i = 0; i < SLOTS && slot == 0; i++)
          if (slot_tbl[i] == it.handle) slot = i + 1;
        for (int i = 0; i < SLOTS && slot == 0; i++)
          if (slot_tbl[i] == 0) begin
            slot_tbl[i] = it.handle;
            slot = i + 1;
          end
      end
      sincos(it.angle, c, s);
      for (int k = 0; k < 4; k++) begin
        dx = (k == 1 || k == 2) ? 64'(it.size_x) : -64'(it.size_x);
        dy = (k >= 2) ? 64'(it.size_y) : -64'(it.size_y);
        ox = asr(dx * c - dy * s + (64'sd1 <<< 30), 31);
        oy = asr(dx * s + dy * c + (64'sd1 <<< 30), 31);
        r = '{qbvg_pkg::KIND_VERTEX, clamp32(64'(it.pos_x) + ox),
              clamp32(64'(it.pos_y) + oy), (k == 1 || k == 2), (k >= 2), it.color,
              5'(slot), 0, 0, 0, (k == 3)};
        expected_beats.push_back(r);
      end
      index_count = (index_count + 19'd6 > INDEX_CAP) ? INDEX_CAP : index_count + 19'd6;
    end
  endtask

  // Driver: offer the next pending item, advance on accept
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) predict_batch(pending_sprites.pop_front());
      if (pending_sprites.size() > 0 && !send_hold &&
          !(idle_enable && $urandom_range(99) < 34)) begin
        in_ch.valid          <= 1'b1;
        in_ch.mode           <= pending_sprites[0].mode;
        in_ch.pos_x          <= pending_sprites[0].pos_x;
        in_ch.pos_y          <= pending_sprites[0].pos_y;
        in_ch.size_x         <= pending_sprites[0].size_x;
        in_ch.size_y         <= pending_sprites[0].size_y;
        in_ch.angle          <= pending_sprites[0].angle;
        in_ch.color          <= pending_sprites[0].color;
        in_ch.texture_handle <= pending_sprites[0].handle;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver stall, long hold-offs counted here
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (sink_holdoff > 0) begin
      sink_holdoff <= sink_holdoff - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !(idle_enable && $urandom_range(99) < 34);
    end
  end

  // Monitor: compare each result beat with the oldest expectation
  always @(posedge clk) begin
    vert_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat kind=%0d", out_ch.kind);
      end else begin
        e = expected_beats.pop_front();
        if (out_ch.kind !== e.kind || out_ch.vertex_x !== e.vx || out_ch.vertex_y !== e.vy ||
            out_ch.tex_u !== e.u || out_ch.tex_v !== e.v ||
            out_ch.vertex_color !== e.color || out_ch.slot_number !== e.slot ||
            out_ch.bound_handle !== e.handle || out_ch.total_indices !== e.total ||
            out_ch.line_mode !== e.line || out_ch.last !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp k%0d x%h y%h uv%b%b c%h s%0d h%h t%0d l%b e%b",
                     e.kind, e.vx, e.vy, e.u, e.v, e.color, e.slot, e.handle,
                     e.total, e.line, e.last,
                     "\n         got k%0d x%h y%h uv%b%b c%h s%0d h%h t%0d l%b e%b",
                     out_ch.kind, out_ch.vertex_x, out_ch.vertex_y, out_ch.tex_u,
                     out_ch.tex_v, out_ch.vertex_color, out_ch.slot_number,
                     out_ch.bound_handle, out_ch.total_indices, out_ch.line_mode,
                     out_ch.last);
        end
      end
    end
  end

  function automatic sprite_t make_sprite(logic [1:0] mode, logic [31:0] handle);
    sprite_t it;
    it.mode   = mode;
    it.pos_x  = $urandom;
    it.pos_y  = $urandom;
    it.size_x = $urandom;
    it.size_y = $urandom;
    it.angle  = 16'($urandom);
    it.color  = $urandom;
    it.handle = handle;
    // mostly sensible sprites, some full-range
    if ($urandom_range(3) != 0) begin
      it.pos_x  = $signed(32'($urandom_range(2000000))) - 1000000;
      it.pos_y  = $signed(32'($urandom_range(2000000))) - 1000000;
      it.size_x = $urandom_range(3000000);
      it.size_y = $urandom_range(3000000);
    end
    return it;
  endfunction

  function automatic logic [31:0] pick_handle();
    case ($urandom_range(5))
      0: return 0;
      1: return $urandom;
      default: return $urandom_range(40, 1);
    endcase
  endfunction

  task automatic drain();
    while (pending_sprites.size() > 0 || in_ch.valid || expected_beats.size() > 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_line_mode(input logic val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    line_flag = val;
  endtask

  initial begin
    sprite_t it;
    int sent;
    int n;
    for (int i = 0; i < SLOTS; i++) slot_tbl[i] = 0;
    index_count = 0;
    line_flag = 0;
    in_ch.valid = 0; in_ch.mode = qbvg_pkg::MODE_BEGIN; in_ch.pos_x = 0; in_ch.pos_y = 0;
    in_ch.size_x = 0; in_ch.size_y = 0; in_ch.angle = 0; in_ch.color = 0;
    in_ch.texture_handle = 0;
    out_ch.ready = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, every mode, null handle, draw without begin
    it = make_sprite(qbvg_pkg::MODE_PLAIN, 0);
    it.pos_x = 32'h7fffffff; it.pos_y = 32'h80000000; it.size_x = 32'h7fffffff;
    it.size_y = 32'h80000000; it.angle = 16'h7fff; it.color = 32'hffffffff;
    pending_sprites.push_back(it);
    it.pos_x = 32'h80000000; it.pos_y = 32'h7fffffff; it.angle = 16'h8000;
    it.color = 0;
    pending_sprites.push_back(it);
    pending_sprites.push_back(make_sprite(qbvg_pkg::MODE_BEGIN, 0));
    for (int a = 0; a < 8; a++) begin
      it = make_sprite(qbvg_pkg::MODE_TEX,
                       (a == 0) ? 32'h0 : (a == 1) ? 32'hffffffff : 32'(a));
      it.angle = 16'(a * 3217 - 12868);
      pending_sprites.push_back(it);
    end
    pending_sprites.push_back(make_sprite(qbvg_pkg::MODE_TEX, 32'h5));
    pending_sprites.push_back(make_sprite(qbvg_pkg::MODE_END, 0));
    // Fill all slots, then one more new handle
    pending_sprites.push_back(make_sprite(qbvg_pkg::MODE_BEGIN, 0));
    for (int h = 0; h < 32; h++)
      pending_sprites.push_back(make_sprite(qbvg_pkg::MODE_TEX, 32'(100 + h)));
    pending_sprites.push_back(make_sprite(qbvg_pkg::MODE_END, 0));
    pending_sprites.push_back(make_sprite(qbvg_pkg::MODE_END, 0));
    drain();
    write_line_mode(1'b1);

    // Random batches; long receiver hold-off during the first
    sent = 0;
    sink_holdoff = 300;
    idle_enable = 0;
    while (sent < 270) begin
      if (sent > 60) idle_enable = 1;
      if ($urandom_range(9) == 0) begin
        it = make_sprite(2'($urandom), pick_handle());
        pending_sprites.push_back(it);
        sent++;
      end else begin
        pending_sprites.push_back(make_sprite(qbvg_pkg::MODE_BEGIN, 0));
        n = $urandom_range(8);
        repeat (n) begin
          it = make_sprite($urandom_range(1) ? qbvg_pkg::MODE_TEX : qbvg_pkg::MODE_PLAIN,
                           pick_handle());
          pending_sprites.push_back(it);
        end
        pending_sprites.push_back(make_sprite(qbvg_pkg::MODE_END, 0));
        sent += n + 2;
      end
      if (sent > 150 && sent < 165) begin
        drain();
        write_line_mode(1'b0);
      end
      while (pending_sprites.size() > 20) @(posedge clk);
    end
    // Sender pause until all results are in
    send_hold = 1;
    while (in_ch.valid || expected_beats.size() > 0) @(posedge clk);
    write_line_mode(1'b1);
    send_hold = 0;
    pending_sprites.push_back(make_sprite(qbvg_pkg::MODE_TEX, 32'd9));
    pending_sprites.push_back(make_sprite(qbvg_pkg::MODE_END, 0));
    drain();

    if (mismatches == 0 && expected_beats.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/qbvg_pkg.sv
src/qbvg_in_if.sv
src/qbvg_out_if.sv
src/qbvg_front.sv
src/qbvg_fifo.sv
src/qbvg_back.sv
src/quad_batch_vertex_generator_top.sv
dv/tb_quad_batch_vertex_generator_top.sv
